>>> rtl/sliding_window_median_core_assert.svh
// ----------------------------------------------------------------------------
// sliding window median assertion macros
// concurrent checks clocked on clk_i, disabled while rst_ni is low
// ----------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_MEDIAN_CORE_ASSERT_SVH
`define SLIDING_WINDOW_MEDIAN_CORE_ASSERT_SVH

// expression holds at every edge
`define SWM_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define SWM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/swm_pkg.sv
// ----------------------------------------------------------------------------
// swm_pkg
// shared constants and types of the sliding window median filter
// ----------------------------------------------------------------------------
package swm_pkg;

  localparam int WINDOW_MAX_DEF   = 64;
  localparam int SAMPLE_WIDTH_DEF = 32;
  localparam int CFG_W            = 7;
  localparam logic [CFG_W-1:0] LEN_RESET = 7'd3;

  // control shared by every cell of the row
  typedef struct packed {
    logic clr;
    logic push;
    logic remove;
    logic rem_left;
  } ctl_t;

endpackage

>>> rtl/swm_stream_if.sv
// ----------------------------------------------------------------------------
// swm stream interfaces
// valid/ready channels for incoming samples and outgoing medians
// ----------------------------------------------------------------------------
interface swm_sample_if #(
  parameter int SAMPLE_WIDTH = swm_pkg::SAMPLE_WIDTH_DEF
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface swm_median_if #(
  parameter int SAMPLE_WIDTH = swm_pkg::SAMPLE_WIDTH_DEF
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] median;

  modport source (output valid, output median, input ready);
  modport sink   (input valid, input median, output ready);
endinterface

>>> rtl/swm_cell.sv
// ----------------------------------------------------------------------------
// swm_cell
// one sorted window slot: holds a sample, its age and a valid flag, and
// takes its next content from itself, a neighbor or the new sample
// ----------------------------------------------------------------------------
module swm_cell #(
  parameter int SAMPLE_WIDTH = swm_pkg::SAMPLE_WIDTH_DEF,
  parameter int IDX_W        = 6,
  parameter int INDEX        = 0
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  swm_pkg::ctl_t                  ctl_i,
  input  logic signed [SAMPLE_WIDTH-1:0] x_i,
  input  logic [IDX_W-1:0]               tgt_age_i,
  input  logic [IDX_W-1:0]               med_idx_i,
  input  logic signed [SAMPLE_WIDTH-1:0] left_val_i,
  input  logic [IDX_W-1:0]               left_age_i,
  input  logic                           left_valid_i,
  input  logic                           left_le_i,
  input  logic signed [SAMPLE_WIDTH-1:0] right_val_i,
  input  logic [IDX_W-1:0]               right_age_i,
  input  logic                           right_valid_i,
  input  logic                           right_le_i,
  input  logic                           rem_i,
  input  logic                           rl_i,
  input  logic [SAMPLE_WIDTH-1:0]        med_i,
  output logic signed [SAMPLE_WIDTH-1:0] val_o,
  output logic [IDX_W-1:0]               age_o,
  output logic                           valid_o,
  output logic                           le_o,
  output logic                           rem_o,
  output logic                           rl_o,
  output logic [SAMPLE_WIDTH-1:0]        med_o
);
  import swm_pkg::*;

  typedef enum logic [1:0] {
    ACT_HOLD,
    ACT_LOAD,
    ACT_LEFT,
    ACT_RIGHT
  } act_e;

  logic signed [SAMPLE_WIDTH-1:0] val_q, val_d;
  logic [IDX_W-1:0]               age_q, age_d;
  logic                           valid_q, valid_d;
  logic                           le, rem, req, is_med;
  logic signed [SAMPLE_WIDTH-1:0] med_cand;
  act_e                           act;

  assign le     = valid_q && (val_q <= x_i);
  assign rem    = ctl_i.remove && valid_q && (age_q == tgt_age_i);
  assign req    = rem_i || rem;
  assign is_med = (med_idx_i == IDX_W'(INDEX));

  // slot position relative to insert point and removed slot
  always_comb begin
    act = ACT_HOLD;
    if (ctl_i.push) begin
      priority if (!ctl_i.remove) begin
        if (le)             act = ACT_HOLD;
        else if (left_le_i) act = ACT_LOAD;
        else                act = ACT_LEFT;
      end else if (ctl_i.rem_left) begin
        if (!req)            act = ACT_HOLD;
        else if (right_le_i) act = ACT_RIGHT;
        else if (le)         act = ACT_LOAD;
        else                 act = ACT_HOLD;
      end else begin
        if (le)             act = ACT_HOLD;
        else if (left_le_i) act = ACT_LOAD;
        else if (!rem_i)    act = ACT_LEFT;
        else                act = ACT_HOLD;
      end
    end
  end

  always_comb begin
    val_d   = val_q;
    age_d   = age_q;
    valid_d = valid_q;
    unique case (act)
      ACT_HOLD: begin
        if (ctl_i.push) age_d = age_q + 1'b1;
      end
      ACT_LOAD: begin
        val_d   = x_i;
        age_d   = '0;
        valid_d = 1'b1;
      end
      ACT_LEFT: begin
        val_d   = left_val_i;
        age_d   = left_age_i + 1'b1;
        valid_d = left_valid_i;
      end
      ACT_RIGHT: begin
        val_d   = right_val_i;
        age_d   = right_age_i + 1'b1;
        valid_d = right_valid_i;
      end
      default: begin
        val_d = val_q;
      end
    endcase
    if (ctl_i.clr) valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      age_q   <= '0;
    end else begin
      valid_q <= valid_d;
      age_q   <= age_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  // median of window including the new sample, taken before the update
  always_comb begin
    if (le)             med_cand = val_q;
    else if (left_le_i) med_cand = x_i;
    else                med_cand = left_val_i;
  end

  assign med_o   = med_i | (is_med ? med_cand : '0);
  assign rem_o   = req;
  assign rl_o    = rl_i || (rem && le);
  assign val_o   = val_q;
  assign age_o   = age_q;
  assign valid_o = valid_q;
  assign le_o    = le;

endmodule

>>> rtl/sliding_window_median_core.sv
// ----------------------------------------------------------------------------
// sliding_window_median_core
// running lower median over the last window_len signed samples
// ----------------------------------------------------------------------------
// usage:
//   src_i takes one sample per request (valid/ready), dst_o returns one
//   median per request once the window is full; the first window_len-1
//   samples after reset or a length write give no result
//   cfg_we_i/cfg_wdata_i write window_len (0 acts as 1, above WINDOW_MAX
//   acts as WINDOW_MAX) and empty the window; write only while idle
//   latency: the median shows on dst_o one cycle after its sample is taken
//   throughput: one sample per cycle; a row of WINDOW_MAX sorted cells
//   inserts the new sample and drops the oldest in a single cycle
//   a stalled dst_o holds the median; src_i then still takes samples that
//   give no result, and otherwise waits until the median is taken
//   reset empties the window and sets window_len to 3
// ----------------------------------------------------------------------------
`include "sliding_window_median_core_assert.svh"

module sliding_window_median_core #(
  parameter int WINDOW_MAX   = swm_pkg::WINDOW_MAX_DEF,
  parameter int SAMPLE_WIDTH = swm_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [swm_pkg::CFG_W-1:0] cfg_wdata_i,
  swm_sample_if.sink                src_i,
  swm_median_if.source              dst_o
);
  import swm_pkg::*;

  localparam int IDX_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;

  function automatic logic [IDX_W-1:0] len_m1(logic [CFG_W-1:0] w);
    logic [IDX_W-1:0] r;
    if (w == '0)                          r = '0;
    else if (int'(w) > WINDOW_MAX)        r = IDX_W'(WINDOW_MAX - 1);
    else                                  r = IDX_W'(w - 1'b1);
    return r;
  endfunction

  logic [IDX_W-1:0]               lenm1_q, fill_q, fill_d;
  logic [IDX_W-1:0]               med_idx, tgt_age;
  logic                           out_valid_q, out_valid_d;
  logic signed [SAMPLE_WIDTH-1:0] median_q;
  logic                           accept, full, in_ready;
  ctl_t                           ctl;

  logic signed [SAMPLE_WIDTH-1:0] val_x   [WINDOW_MAX+2];
  logic [IDX_W-1:0]               age_x   [WINDOW_MAX+2];
  logic                           valid_x [WINDOW_MAX+2];
  logic                           le_x    [WINDOW_MAX+2];
  logic                           rem_c   [WINDOW_MAX+1];
  logic                           rl_c    [WINDOW_MAX+1];
  logic [SAMPLE_WIDTH-1:0]        med_c   [WINDOW_MAX+1];
  logic [WINDOW_MAX-1:0]          valid_vec;

  assign med_idx  = lenm1_q >> 1;
  assign tgt_age  = lenm1_q - 1'b1;
  assign full     = (fill_q == lenm1_q);
  assign in_ready = !out_valid_q || dst_o.ready || !full;
  assign accept   = src_i.valid && in_ready;

  assign ctl.clr      = cfg_we_i;
  assign ctl.push     = accept && (lenm1_q != '0);
  assign ctl.remove   = full;
  assign ctl.rem_left = rl_c[WINDOW_MAX];

  // row boundaries
  assign val_x[0]              = '0;
  assign age_x[0]              = '0;
  assign valid_x[0]            = 1'b0;
  assign le_x[0]               = 1'b1;
  assign val_x[WINDOW_MAX+1]   = '0;
  assign age_x[WINDOW_MAX+1]   = '0;
  assign valid_x[WINDOW_MAX+1] = 1'b0;
  assign le_x[WINDOW_MAX+1]    = 1'b0;
  assign rem_c[0]              = 1'b0;
  assign rl_c[0]               = 1'b0;
  assign med_c[0]              = '0;

  for (genvar g = 0; g < WINDOW_MAX; g++) begin : g_cell
    swm_cell #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .IDX_W        (IDX_W),
      .INDEX        (g)
    ) u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctl_i         (ctl),
      .x_i           (src_i.sample),
      .tgt_age_i     (tgt_age),
      .med_idx_i     (med_idx),
      .left_val_i    (val_x[g]),
      .left_age_i    (age_x[g]),
      .left_valid_i  (valid_x[g]),
      .left_le_i     (le_x[g]),
      .right_val_i   (val_x[g+2]),
      .right_age_i   (age_x[g+2]),
      .right_valid_i (valid_x[g+2]),
      .right_le_i    (le_x[g+2]),
      .rem_i         (rem_c[g]),
      .rl_i          (rl_c[g]),
      .med_i         (med_c[g]),
      .val_o         (val_x[g+1]),
      .age_o         (age_x[g+1]),
      .valid_o       (valid_x[g+1]),
      .le_o          (le_x[g+1]),
      .rem_o         (rem_c[g+1]),
      .rl_o          (rl_c[g+1]),
      .med_o         (med_c[g+1])
    );
    assign valid_vec[g] = valid_x[g+1];
  end

  always_comb begin
    fill_d = fill_q;
    if (cfg_we_i)                       fill_d = '0;
    else if (ctl.push && !ctl.remove)   fill_d = fill_q + 1'b1;
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (accept && full)   out_valid_d = 1'b1;
    else if (dst_o.ready) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lenm1_q     <= len_m1(LEN_RESET);
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) lenm1_q <= len_m1(cfg_wdata_i);
      fill_q      <= fill_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && full) median_q <= med_c[WINDOW_MAX];
  end

  assign src_i.ready  = in_ready;
  assign dst_o.valid  = out_valid_q;
  assign dst_o.median = median_q;

  `SWM_ASSERT_ALWAYS(a_fill_range, fill_q <= lenm1_q, "fill count beyond window")
  `SWM_ASSERT_ALWAYS(a_fill_cells, $countones(valid_vec) == int'(fill_q), "cells disagree with fill")
  `SWM_ASSERT_ALWAYS(a_cells_packed, ((valid_vec + 1'b1) & valid_vec) == '0, "cell row has a hole")
  `SWM_ASSERT_NEXT(a_result_out, accept && full, dst_o.valid, "median not presented")

endmodule
